### rtl/core/assert_macros.svh
// Assertion macros for the label bounding box tracker.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/core/lbbt_pkg.sv
// Shared types, codes and constants of the label bounding box tracker.
// Depends on nothing.
package lbbt_pkg;

  localparam int REG_W       = 13;
  localparam int BOX_W       = 12;
  localparam int COLOUR_W    = 8;
  localparam int TRACK_W     = 16;
  localparam int CLASS_W     = 8;
  localparam int LABEL_W     = 8;
  localparam int KIND_W      = 2;
  localparam int CFG_INDEX_W = 1;

  localparam int LABEL_COUNT_DEFAULT = 256;
  localparam int COORD_BITS_DEFAULT  = 12;

  localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd1920;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd1080;

  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TABLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [LABEL_W-1:0]  label;
    logic [TRACK_W-1:0]  track_id;
    logic [CLASS_W-1:0]  class_id;
    logic [COLOUR_W-1:0] mask_red;
    logic [COLOUR_W-1:0] mask_green;
    logic [COLOUR_W-1:0] mask_blue;
  } item_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] out_red;
    logic [COLOUR_W-1:0] out_green;
    logic [COLOUR_W-1:0] out_blue;
    logic                present;
    logic [BOX_W-1:0]    box_x_min;
    logic [BOX_W-1:0]    box_x_max;
    logic [BOX_W-1:0]    box_y_min;
    logic [BOX_W-1:0]    box_y_max;
    logic [TRACK_W-1:0]  report_track;
    logic [CLASS_W-1:0]  report_class;
    logic                crowd;
  } result_t;

  typedef struct packed {
    logic [TRACK_W-1:0]  track;
    logic [CLASS_W-1:0]  class_id;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic update;
  } box_cmd_t;

endpackage

### rtl/core/label_bounding_box_tracker.sv
// Label bounding box tracker, top level. An item is registered in stage s1,
// then in the result register. Throughput one item per cycle while the output
// is not stalled, set by the box memory read-modify-write, which bypasses the
// previous item's write. Reset: counters zero, frame size 1920 x 1080, seen
// flags cleared at once; label table and box memory hold nothing defined
// until written. Depends on lbbt_pkg, assert_macros.svh and the submodules.
`include "assert_macros.svh"
module label_bounding_box_tracker #(
  parameter int LABEL_COUNT = lbbt_pkg::LABEL_COUNT_DEFAULT,
  parameter int COORD_BITS  = lbbt_pkg::COORD_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lbbt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lbbt_pkg::REG_W-1:0]       cfg_data,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  lbbt_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output lbbt_pkg::result_t                result
);
  import lbbt_pkg::*;

  localparam int IDX_W = $clog2(LABEL_COUNT);
  localparam int LW1   = LABEL_W + 1;
  localparam logic [LW1-1:0] LABEL_LIMIT = LW1'(LABEL_COUNT);

  logic                  item_fire;
  logic                  advance;
  logic                  s1_go;
  logic                  s1_valid;
  item_t                 s1_item;
  logic [COORD_BITS-1:0] s1_x;
  logic [COORD_BITS-1:0] s1_y;
  logic                  s1_first;
  logic                  in_ok;
  logic [IDX_W-1:0]      in_idx;
  logic                  s1_ok;
  logic                  s1_nonzero;
  logic [IDX_W-1:0]      s1_idx;
  logic [COORD_BITS-1:0] cnt_x;
  logic [COORD_BITS-1:0] cnt_y;
  logic                  cnt_first;
  entry_t                tbl_wdata;
  entry_t                tbl_q;
  box_cmd_t              cmd;
  logic                  box_present;
  logic [COORD_BITS-1:0] bx_min;
  logic [COORD_BITS-1:0] bx_max;
  logic [COORD_BITS-1:0] by_min;
  logic [COORD_BITS-1:0] by_max;
  result_t               res;

  assign advance    = !result_valid || result_ready;
  assign item_ready = !s1_valid || advance;
  assign item_fire  = item_valid && item_ready;
  assign s1_go      = s1_valid && advance;

  assign in_ok      = {1'b0, item.label} < LABEL_LIMIT;
  assign in_idx     = item.label[IDX_W-1:0];
  assign s1_ok      = {1'b0, s1_item.label} < LABEL_LIMIT;
  assign s1_idx     = s1_item.label[IDX_W-1:0];
  assign s1_nonzero = s1_item.label != '0;

  assign tbl_wdata = '{track: item.track_id, class_id: item.class_id,
                       red: item.mask_red, green: item.mask_green,
                       blue: item.mask_blue};

  assign cmd.clear  = s1_go && (s1_item.kind == KIND_PIXEL) && s1_first;
  assign cmd.update = s1_go && (s1_item.kind == KIND_PIXEL) && s1_ok && s1_nonzero;

  lbbt_raster_counter #(.COORD_BITS(COORD_BITS)) u_counter (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (item_fire && (item.kind == KIND_PIXEL)),
    .x         (cnt_x),
    .y         (cnt_y),
    .first     (cnt_first)
  );

  lbbt_label_table #(.LABEL_COUNT(LABEL_COUNT)) u_table (
    .clk   (clk),
    .we    (item_fire && (item.kind == KIND_TABLE) && in_ok),
    .waddr (in_idx),
    .wdata (tbl_wdata),
    .re    (item_fire),
    .raddr (in_idx),
    .rdata (tbl_q)
  );

  lbbt_box_tracker #(
    .LABEL_COUNT (LABEL_COUNT),
    .COORD_BITS  (COORD_BITS)
  ) u_boxes (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (item_fire),
    .rd_idx  (in_idx),
    .cmd     (cmd),
    .idx     (s1_idx),
    .first   (s1_first),
    .x       (s1_x),
    .y       (s1_y),
    .present (box_present),
    .x_min   (bx_min),
    .x_max   (bx_max),
    .y_min   (by_min),
    .y_max   (by_max)
  );

  always_comb begin
    res = '0;
    case (s1_item.kind)
      KIND_PIXEL: begin
        if (s1_ok && s1_nonzero) begin
          res.out_red   = tbl_q.red;
          res.out_green = tbl_q.green;
          res.out_blue  = tbl_q.blue;
        end
      end
      KIND_QUERY: begin
        if (s1_ok) begin
          if (s1_nonzero && box_present) begin
            res.present   = 1'b1;
            res.box_x_min = BOX_W'(bx_min);
            res.box_x_max = BOX_W'(bx_max);
            res.box_y_min = BOX_W'(by_min);
            res.box_y_max = BOX_W'(by_max);
          end
          res.report_track = tbl_q.track;
          res.report_class = tbl_q.class_id;
          res.crowd        = tbl_q.track == '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1_item  <= item;
      s1_x     <= cnt_x;
      s1_y     <= cnt_y;
      s1_first <= cnt_first && (item.kind == KIND_PIXEL);
    end
    if (s1_go) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  `ASSERT_IMPLIES(a_ready_only_on_stall, clk, rst, !item_ready, s1_valid && result_valid && !result_ready, "input stalled without a full pipeline")
  `ASSERT_NEXT(a_stage_to_result, clk, rst, s1_go, result_valid, "stage transfer produced no result")
  `ASSERT_NEXT(a_stage_hold, clk, rst, s1_valid && !advance, s1_valid && $stable(s1_item), "stalled stage lost its item")

endmodule

### rtl/core/lbbt_raster_counter.sv
// Frame size registers and raster column/line counters.
// Depends on lbbt_pkg.
module lbbt_raster_counter #(
  parameter int COORD_BITS = lbbt_pkg::COORD_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lbbt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lbbt_pkg::REG_W-1:0]         cfg_data,
  input  logic                               step,
  output logic [COORD_BITS-1:0]              x,
  output logic [COORD_BITS-1:0]              y,
  output logic                               first
);
  import lbbt_pkg::*;

  localparam int SW = (COORD_BITS + 1 > REG_W) ? COORD_BITS + 1 : REG_W;
  localparam logic [SW-1:0] LIMIT = SW'(1) << COORD_BITS;

  logic [REG_W-1:0]      frame_width;
  logic [REG_W-1:0]      frame_height;
  logic [COORD_BITS-1:0] column_count;
  logic [COORD_BITS-1:0] line_count;
  logic [COORD_BITS-1:0] column_next;
  logic [COORD_BITS-1:0] line_next;
  logic [SW-1:0]         width_eff;
  logic [SW-1:0]         height_eff;
  logic [SW-1:0]         col_inc;
  logic [SW-1:0]         line_inc;

  function automatic logic [SW-1:0] clamp_size(input logic [REG_W-1:0] r);
    logic [SW-1:0] v;
    v = SW'(r);
    if (v == '0) begin
      return SW'(1);
    end else if (v > LIMIT) begin
      return LIMIT;
    end
    return v;
  endfunction

  always_comb begin
    width_eff  = clamp_size(frame_width);
    height_eff = clamp_size(frame_height);
    col_inc    = SW'(column_count) + SW'(1);
    line_inc   = SW'(line_count) + SW'(1);
    if (col_inc >= width_eff) begin
      column_next = '0;
      if (line_inc >= height_eff) begin
        line_next = '0;
      end else begin
        line_next = line_inc[COORD_BITS-1:0];
      end
    end else begin
      column_next = col_inc[COORD_BITS-1:0];
      line_next   = line_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      column_count <= '0;
      line_count   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
      if (step) begin
        column_count <= column_next;
        line_count   <= line_next;
      end
    end
  end

  assign x     = column_count;
  assign y     = line_count;
  assign first = (column_count == '0) && (line_count == '0);

endmodule

### rtl/core/lbbt_label_table.sv
// Label table memory: track id, class and mask colour per label.
// Depends on lbbt_pkg; one write port, one registered read port.
module lbbt_label_table #(
  parameter int LABEL_COUNT = lbbt_pkg::LABEL_COUNT_DEFAULT
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(LABEL_COUNT)-1:0] waddr,
  input  lbbt_pkg::entry_t               wdata,
  input  logic                           re,
  input  logic [$clog2(LABEL_COUNT)-1:0] raddr,
  output lbbt_pkg::entry_t               rdata
);
  import lbbt_pkg::*;

  entry_t mem [LABEL_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/lbbt_box_tracker.sv
// Box memory with read-modify-write, bypass of the previous write, seen flags.
// Depends on lbbt_pkg.
module lbbt_box_tracker #(
  parameter int LABEL_COUNT = lbbt_pkg::LABEL_COUNT_DEFAULT,
  parameter int COORD_BITS  = lbbt_pkg::COORD_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rd_en,
  input  logic [$clog2(LABEL_COUNT)-1:0] rd_idx,
  input  lbbt_pkg::box_cmd_t             cmd,
  input  logic [$clog2(LABEL_COUNT)-1:0] idx,
  input  logic                           first,
  input  logic [COORD_BITS-1:0]          x,
  input  logic [COORD_BITS-1:0]          y,
  output logic                           present,
  output logic [COORD_BITS-1:0]          x_min,
  output logic [COORD_BITS-1:0]          x_max,
  output logic [COORD_BITS-1:0]          y_min,
  output logic [COORD_BITS-1:0]          y_max
);
  import lbbt_pkg::*;

  localparam int BOX_BITS = 4 * COORD_BITS;

  logic [BOX_BITS-1:0]    box_mem [LABEL_COUNT];
  logic [BOX_BITS-1:0]    box_q;
  logic [BOX_BITS-1:0]    fwd_box;
  logic                   fwd_hit;
  logic [LABEL_COUNT-1:0] seen;
  logic [LABEL_COUNT-1:0] seen_set;
  logic [BOX_BITS-1:0]    cur;
  logic [BOX_BITS-1:0]    box_next;
  logic                   seen_now;
  logic [COORD_BITS-1:0]  nx_min;
  logic [COORD_BITS-1:0]  nx_max;
  logic [COORD_BITS-1:0]  ny_min;
  logic [COORD_BITS-1:0]  ny_max;

  always_comb begin
    cur      = fwd_hit ? fwd_box : box_q;
    x_min    = cur[4*COORD_BITS-1:3*COORD_BITS];
    x_max    = cur[3*COORD_BITS-1:2*COORD_BITS];
    y_min    = cur[2*COORD_BITS-1:COORD_BITS];
    y_max    = cur[COORD_BITS-1:0];
    seen_now = !first && seen[idx];
    if (seen_now) begin
      nx_min = (x < x_min) ? x : x_min;
      nx_max = (x > x_max) ? x : x_max;
      ny_min = (y < y_min) ? y : y_min;
      ny_max = (y > y_max) ? y : y_max;
    end else begin
      nx_min = x;
      nx_max = x;
      ny_min = y;
      ny_max = y;
    end
    box_next = {nx_min, nx_max, ny_min, ny_max};
    seen_set = {{(LABEL_COUNT-1){1'b0}}, 1'b1} << idx;
  end

  assign present = seen_now;

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      box_mem[idx] <= box_next;
    end
    if (rd_en) begin
      box_q   <= box_mem[rd_idx];
      fwd_box <= box_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
      seen    <= '0;
    end else begin
      if (rd_en) begin
        fwd_hit <= cmd.update && (rd_idx == idx);
      end
      if (cmd.clear && cmd.update) begin
        seen <= seen_set;
      end else if (cmd.clear) begin
        seen <= '0;
      end else if (cmd.update) begin
        seen <= seen | seen_set;
      end
    end
  end

endmodule
